>>> rtl/lrumtf_pkg.sv
// lrumtf_pkg: shared widths, defaults and types for the move-to-front recency list
// no dependencies; compiled first
package lrumtf_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned PosW        = 6;
  localparam int unsigned DefCapacity = 8;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW       = $clog2(QDepth + 1);

  // pending access handed from the front queue to the back engine
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
  } key_req_t;

endpackage

>>> rtl/lrumtf_if.sv
// lrumtf_if: valid/ready channels for accessed keys and listing results
// depends on lrumtf_pkg
interface lrumtf_key_if import lrumtf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [KeyW-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface lrumtf_res_if import lrumtf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic        [PosW-1:0] position;
  logic signed [KeyW-1:0] entry_key;
  logic                   was_hit;
  logic                   last_entry;

  modport source (output valid, output position, output entry_key, output was_hit,
                  output last_entry, input ready);
  modport sink   (input valid, input position, input entry_key, input was_hit,
                  input last_entry, output ready);
endinterface

>>> rtl/lrumtf_front.sv
// lrumtf_front: accepts keys and holds them in a short queue for the back engine
// depends on lrumtf_pkg
module lrumtf_front import lrumtf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [KeyW-1:0] in_key_i,
  output key_req_t               req_o,
  input  logic                   pop_i
);

  logic signed [KeyW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0]       wptr_q, wptr_d;
  logic [QPtrW-1:0]       rptr_q, rptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   push, pop;

  assign in_ready_o = (cnt_q != QCntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign req_o.valid = (cnt_q != '0);
  assign req_o.key   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_key_i;
    end
  end

endmodule

>>> rtl/lrumtf_back.sv
// lrumtf_back: compares, reorders the recency list and streams it out entry by entry
// depends on lrumtf_pkg
module lrumtf_back import lrumtf_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  key_req_t               req_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic        [PosW-1:0] out_position_o,
  output logic signed [KeyW-1:0] out_entry_key_o,
  output logic                   out_was_hit_o,
  output logic                   out_last_entry_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  typedef logic [CAPACITY-1:0] vec_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic signed [KeyW-1:0] list_q [CAPACITY];
  logic signed [KeyW-1:0] list_d [CAPACITY];
  logic signed [KeyW-1:0] key_q, key_d;
  vec_t                   match_q, match_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic                   is_last;
  logic                   hit;
  vec_t                   first;
  vec_t                   shift_mask;

  logic        [PosW-1:0] pos_q;
  logic signed [KeyW-1:0] ekey_q;
  logic                   ohit_q;
  logic                   olast_q;

  assign is_last  = (idx_q == IdxW'(CAPACITY - 1));
  // output register frees up when empty or taken this cycle
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign pop_o    = (state_q == ST_IDLE) && req_i.valid;

  // lowest matching position; entries up to it shift back, a miss shifts all
  assign hit        = |match_q;
  assign first      = match_q & (~match_q + vec_t'(1));
  assign shift_mask = hit ? (first | (first - vec_t'(1))) : '1;

  always_comb begin
    state_d     = state_q;
    list_d      = list_q;
    key_d       = key_q;
    match_d     = match_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d = req_i.key;
          for (int i = 0; i < CAPACITY; i++) begin
            match_d[i] = (list_q[i] == req_i.key);
          end
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        list_d[0] = key_q;
        for (int i = 1; i < CAPACITY; i++) begin
          list_d[i] = shift_mask[i] ? list_q[i-1] : list_q[i];
        end
        hit_d   = hit;
        idx_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          // rotate so the next entry sits at the head
          for (int i = 0; i < CAPACITY - 1; i++) begin
            list_d[i] = list_q[i+1];
          end
          list_d[CAPACITY-1] = list_q[0];
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        list_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      list_q      <= list_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    match_q <= match_d;
    if (out_load) begin
      pos_q   <= PosW'(idx_q);
      ekey_q  <= list_q[0];
      ohit_q  <= hit_q;
      olast_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_position_o   = pos_q;
  assign out_entry_key_o  = ekey_q;
  assign out_was_hit_o    = ohit_q;
  assign out_last_entry_o = olast_q;

endmodule

>>> rtl/lru_move_to_front_list.sv
// lru_move_to_front_list: recency-ordered key list with move-to-front on access
// depends on lrumtf_pkg, lrumtf_if, lrumtf_front, lrumtf_back
//
//   channel  dir  carries                                       transfer when
//   key_i    in   key                                           valid && ready
//   res_o    out  position, entry_key, was_hit, last_entry      valid && ready
//
// each access passes through the back engine as a compare step and a reorder
// step, then one listing entry per cycle through the output register while the
// sink is ready; the register bounds the rate, a stalled sink holds the listing in place
// the front queue keeps taking keys (two deep) while the back engine is busy
// reset clears the list to all zeros at once; no clearing pass
module lru_move_to_front_list import lrumtf_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrumtf_key_if.sink  key_i,
  lrumtf_res_if.source res_o
);

  // hand-off from the queue to the reorder engine
  key_req_t req;
  logic     pop;

  // front: accept transfers and buffer keys
  lrumtf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_i.valid),
    .in_ready_o (key_i.ready),
    .in_key_i   (key_i.key),
    .req_o      (req),
    .pop_i      (pop)
  );

  // back: search, move to front, then list every position in order
  lrumtf_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .pop_o            (pop),
    .out_valid_o      (res_o.valid),
    .out_ready_i      (res_o.ready),
    .out_position_o   (res_o.position),
    .out_entry_key_o  (res_o.entry_key),
    .out_was_hit_o    (res_o.was_hit),
    .out_last_entry_o (res_o.last_entry)
  );

endmodule

>>> dv/lrumtf_scoreboard_pkg.sv
`timescale 1ns / 100ps
// lrumtf_scoreboard_pkg: recency-list predictor and listing checker for the tb
// depends on lrumtf_pkg
package lrumtf_scoreboard_pkg;
  import lrumtf_pkg::*;

  typedef struct packed {
    logic        [PosW-1:0] position;
    logic signed [KeyW-1:0] entry_key;
    logic                   was_hit;
    logic                   last_entry;
  } listing_entry_t;

  class listing_scoreboard #(int unsigned Cap = DefCapacity);
    logic signed [KeyW-1:0] recency[Cap];
    listing_entry_t         listing_q[$];
    int unsigned            errors;

    function new();
      foreach (recency[i]) recency[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return listing_q.size();
    endfunction

    function logic signed [KeyW-1:0] entry_at(int unsigned idx);
      return recency[idx];
    endfunction

    // move-to-front update for one accepted key, then queue the whole listing
    function void note_key(logic signed [KeyW-1:0] k);
      int unsigned    found;
      bit             hit;
      listing_entry_t e;
      found = Cap;
      for (int unsigned i = 0; i < Cap; i++) begin
        if (found == Cap && recency[i] == k) found = i;
      end
      hit = (found < Cap);
      if (!hit) found = Cap - 1;
      for (int i = found; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = k;
      for (int unsigned i = 0; i < Cap; i++) begin
        e.position   = i[PosW-1:0];
        e.entry_key  = recency[i];
        e.was_hit    = hit;
        e.last_entry = (i == Cap - 1);
        listing_q.push_back(e);
      end
    endfunction

    function void check_entry(listing_entry_t got);
      listing_entry_t exp;
      if (listing_q.size() == 0) begin
        $error("listing entry with nothing pending: position %0d key %0d",
               got.position, got.entry_key);
        errors++;
        return;
      end
      exp = listing_q.pop_front();
      if (got.position !== exp.position) begin
        $error("position: expected %0d, actual %0d", exp.position, got.position);
        errors++;
      end
      if (got.entry_key !== exp.entry_key) begin
        $error("entry_key: expected %0d, actual %0d", exp.entry_key, got.entry_key);
        errors++;
      end
      if (got.was_hit !== exp.was_hit) begin
        $error("was_hit: expected %0b, actual %0b", exp.was_hit, got.was_hit);
        errors++;
      end
      if (got.last_entry !== exp.last_entry) begin
        $error("last_entry: expected %0b, actual %0b", exp.last_entry, got.last_entry);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/lru_move_to_front_list_tb.sv
`timescale 1ns / 100ps
// lru_move_to_front_list_tb: drives random and directed key accesses and checks every
// listing entry against a move-to-front predictor
// depends on lrumtf_pkg, lrumtf_if, lrumtf_scoreboard_pkg and the block itself
module lru_move_to_front_list_tb;
  import lrumtf_pkg::*;
  import lrumtf_scoreboard_pkg::*;

  localparam int unsigned Cap       = DefCapacity;
  localparam int unsigned CycleCap  = 500_000;  // watchdog, far above the slowest run
  localparam int unsigned LongHold  = 400;      // long sink stall, fills the key queue
  localparam int unsigned RandItems = 364;
  localparam int unsigned CalmItems = 60;       // tail of the run with no idling

  typedef lrumtf_scoreboard_pkg::listing_scoreboard #(Cap) scoreboard_t;

  logic clk_i;
  logic rst_ni;

  lrumtf_key_if key_if ();
  lrumtf_res_if res_if ();

  lru_move_to_front_list #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (key_if),
    .res_o (res_if)
  );

  scoreboard_t sb = new();

  // idling controls, flipped by the stimulus between phases
  bit          send_idle_en;
  bit          recv_idle_en;
  int unsigned long_hold_reqs;
  int unsigned cycle_cnt = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("status: fail");
      $finish;
    end
  end

  // result monitor: every listing transfer goes to the checker
  always @(posedge clk_i) begin
    listing_entry_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.position   = res_if.position;
      got.entry_key  = res_if.entry_key;
      got.was_hit    = res_if.was_hit;
      got.last_entry = res_if.last_entry;
      sb.check_entry(got);
    end
  end

  // sink side: random stall bursts, plus one long hold on request
  initial begin : sink_ctrl
    int unsigned hold_cnt;
    int unsigned holds_done;
    hold_cnt   = 0;
    holds_done = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        res_if.ready <= 1'b0;
        hold_cnt--;
      end else if (holds_done != long_hold_reqs) begin
        // counted here so the sender keeps offering keys meanwhile
        holds_done++;
        hold_cnt      = LongHold - 1;
        res_if.ready <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
        hold_cnt      = $urandom_range(1, 19) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // one key transfer; called at a falling edge, returns at the falling edge after the key is taken
  task automatic send_key(input logic signed [KeyW-1:0] k);
    key_if.valid <= 1'b1;
    key_if.key   <= k;
    do @(posedge clk_i); while (!key_if.ready);
    sb.note_key(k);
    @(negedge clk_i);
  endtask

  // send a key, then maybe drop valid for a random burst
  task automatic access_key(input logic signed [KeyW-1:0] k);
    send_key(k);
    if (send_idle_en && $urandom_range(0, 4) == 0) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // sender pause until the whole pending listing has drained
  task automatic drain_listing();
    key_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // random key: mostly current list entries (hits at any depth) or a small pool
  // of recurring keys, so eviction and re-entry both happen often
  function automatic logic signed [KeyW-1:0] pick_key(
    input logic signed [KeyW-1:0] pool[16]
  );
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return sb.entry_at($urandom_range(0, Cap - 1));
    if (r < 75) return pool[$urandom_range(0, 15)];
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh0000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh8000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    logic signed [KeyW-1:0] pool[16];
    int unsigned            mode;

    key_if.valid   = 1'b0;
    key_if.key     = '0;
    send_idle_en   = 1'b1;
    recv_idle_en   = 1'b1;
    long_hold_reqs = 0;
    rst_ni         = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero hits the reset zeros at the front and leaves the list as is
    access_key(32'sh0000_0000);
    access_key(32'sh7fff_ffff);
    access_key(32'sh8000_0000);
    // zero again: first leftover zero, now two places back, moves to the front
    access_key(32'sh0000_0000);
    access_key(-32'sd1);
    access_key(32'sd1);
    access_key(32'sh5555_5555);
    access_key(32'shaaaa_aaaa);
    access_key(32'sh1234_5678);
    access_key(32'shdead_beef);
    // hit at the last position, then in the middle, then at the front
    access_key(32'sh8000_0000);
    access_key(32'sd1);
    access_key(32'sd1);
    // misses that push the last zero out, then zero misses and then hits at the front
    access_key(32'sh7fff_ffff);
    access_key(32'sd3);
    access_key(32'sd4);
    access_key(32'sd5);
    access_key(32'sd6);
    access_key(32'sh0000_0000);
    access_key(32'sh0000_0000);

    foreach (pool[i]) pool[i] = $urandom;

    // back-pressure: sink holds off while keys keep coming, queue fills and stalls
    long_hold_reqs++;
    send_idle_en = 1'b0;
    repeat (16) access_key(pick_key(pool));
    drain_listing();

    // random phases, idling pattern changes every 40 accesses
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) begin
        mode         = $urandom_range(0, 3);
        send_idle_en = mode[0];
        recv_idle_en = mode[1];
      end
      if (n == RandItems / 2) drain_listing();
      access_key(pick_key(pool));
    end

    // final stretch at full rate on both sides
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int unsigned n = 0; n < CalmItems; n++) access_key(pick_key(pool));
    key_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Cap + 10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
